[rtl/pipc_pkg.sv]
// Package for the point-in-polytope collision check.
// Holds the command codes, the internal operation kinds and the operation record
// that the front end passes to the back end. It depends on nothing else.
package pipc_pkg;

   // Command codes of the request cmd field.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // Field widths that the request format fixes.
   localparam int COEF_W  = 18;
   localparam int COORD_W = 32;
   localparam int INDEX_W = 5;

   // Operations that reach the back end after decoding.
   typedef enum logic [1:0] {
      OP_CLEAR = 2'b00,
      OP_WRITE = 2'b01,
      OP_QUERY = 2'b10
   } op_kind_type;

   // One decoded request as it travels through the operation queue.
   typedef struct packed {
      op_kind_type                kind;
      logic [INDEX_W-1:0]         poly_idx;
      logic [INDEX_W-1:0]         face_idx;
      logic                       face_last;
      logic signed [COEF_W-1:0]   coef_x;
      logic signed [COEF_W-1:0]   coef_y;
      logic signed [COEF_W-1:0]   coef_z;
      logic signed [COORD_W-1:0]  face_bound;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
      logic signed [COORD_W-1:0]  point_z;
   } op_type;

endpackage

[rtl/pipc_front.sv]
// Front end of the point-in-polytope collision check.
// Accepts requests, decodes the command and drops requests that change nothing.
// Depends on pipc_pkg.
module pipc_front import pipc_pkg::*; #(
   parameter int NUM_POLYTOPES = 32,
   parameter int MAX_FACES     = 32
) (
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_cmd,
   input  logic [INDEX_W-1:0]         req_poly_index,
   input  logic [INDEX_W-1:0]         req_face_index,
   input  logic                       req_face_last,
   input  logic signed [COEF_W-1:0]   req_coef_x,
   input  logic signed [COEF_W-1:0]   req_coef_y,
   input  logic signed [COEF_W-1:0]   req_coef_z,
   input  logic signed [COORD_W-1:0]  req_face_bound,
   input  logic signed [COORD_W-1:0]  req_point_x,
   input  logic signed [COORD_W-1:0]  req_point_y,
   input  logic signed [COORD_W-1:0]  req_point_z,
   input  logic                       queue_full,
   output logic                       op_push,
   output op_type                     op
);

   logic accept;
   logic write_in_range;

   // A request is taken whenever the operation queue has room.
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // A face write outside the table has no effect and is dropped here.
   assign write_in_range = (9'(req_poly_index) < 9'(NUM_POLYTOPES)) &&
                           (7'(req_face_index) < 7'(MAX_FACES));

   // Classify the request; the unused command code is dropped.
   always_comb begin
      op_push = 1'b0;
      op.kind = OP_QUERY;
      unique case (req_cmd)
         CMD_CLEAR: begin
            op_push = accept;
            op.kind = OP_CLEAR;
         end
         CMD_WRITE: begin
            op_push = accept && write_in_range;
            op.kind = OP_WRITE;
         end
         CMD_QUERY: begin
            op_push = accept;
            op.kind = OP_QUERY;
         end
         default: begin
            op_push = 1'b0;
            op.kind = OP_QUERY;
         end
      endcase
      op.poly_idx   = req_poly_index;
      op.face_idx   = req_face_index;
      op.face_last  = req_face_last;
      op.coef_x     = req_coef_x;
      op.coef_y     = req_coef_y;
      op.coef_z     = req_coef_z;
      op.face_bound = req_face_bound;
      op.point_x    = req_point_x;
      op.point_y    = req_point_y;
      op.point_z    = req_point_z;
   end

endmodule

[rtl/pipc_queue.sv]
// Two-entry operation queue between the front end and the back end.
// Lets the front end keep taking requests while a query is being walked.
// Depends on pipc_pkg.
module pipc_queue import pipc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   output logic   valid,
   input  logic   pop,
   output op_type head_op
);

   localparam int DEPTH = 2;

   op_type     entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'(DEPTH));
   assign valid   = (count_ff != 2'd0);
   assign head_op = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[rtl/pipc_back.sv]
// Back end of the point-in-polytope collision check.
// Holds the face memory and the polytope table, executes clears and face writes,
// and walks stored faces through a multiply-add-compare pipeline for queries.
// Depends on pipc_pkg.
module pipc_back import pipc_pkg::*; #(
   parameter int NUM_POLYTOPES = 32,
   parameter int MAX_FACES     = 32
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   op_valid,
   input  op_type op,
   output logic   op_pop,
   input  logic   rsp_pop,
   output logic   rsp_empty,
   output logic   rsp_hit
);

   localparam int PW     = (NUM_POLYTOPES > 1) ? $clog2(NUM_POLYTOPES) : 1;
   localparam int FW     = $clog2(MAX_FACES);
   localparam int CW     = $clog2(MAX_FACES + 1);
   localparam int AW     = PW + FW;
   localparam int DEPTH  = NUM_POLYTOPES * (2 ** FW);
   localparam int DATA_W = 3 * COEF_W + COORD_W;
   localparam int PROD_W = COEF_W + COORD_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RHS_W  = COORD_W + 16;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Pipeline tag: stage holds a face, the face opens or closes its polytope.
   typedef struct packed {
      logic v;
      logic first;
      logic last;
   } tag_type;

   state_type               state_ff, state_in;
   logic                    valid_ff [NUM_POLYTOPES];
   logic [CW-1:0]           count_ff [NUM_POLYTOPES];
   logic [DATA_W-1:0]       mem [DEPTH];

   logic [PW-1:0]           p_ff, p_in;
   logic [FW-1:0]           f_ff, f_in;
   logic signed [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;
   logic                    hit_ff, hit_in;
   logic                    fail_ff, fail_in;
   logic                    out_full_ff, out_full_in;
   logic                    out_hit_ff;
   logic                    out_load;

   tag_type                 tag1_ff, tag1_in;
   tag_type                 tag2_ff;
   tag_type                 tag3_ff;
   logic [DATA_W-1:0]       rd_data_ff;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [COORD_W-1:0] bound2_ff;
   logic signed [SUM_W-1:0]   lhs_ff;
   logic signed [COORD_W-1:0] bound3_ff;

   logic                    start_query;
   logic                    do_clear;
   logic                    do_write;
   logic [AW-1:0]           wr_addr;
   logic [PW-1:0]           wr_poly;
   logic                    cur_valid;
   logic [CW-1:0]           cur_count;
   logic                    face_is_last;
   logic                    poly_is_last;
   logic                    issue;
   logic signed [COEF_W-1:0]  rd_coef_x, rd_coef_y, rd_coef_z;
   logic signed [COORD_W-1:0] rd_bound;
   logic signed [RHS_W-1:0]   rhs;
   logic                    face_fails;
   logic                    cur_fail;

   // Operation dispatch from the queue, one operation at a time.
   assign op_pop      = op_valid && (state_ff == ST_IDLE);
   assign start_query = op_pop && (op.kind == OP_QUERY);
   assign do_clear    = op_pop && (op.kind == OP_CLEAR);
   assign do_write    = op_pop && (op.kind == OP_WRITE);
   assign wr_poly     = PW'(op.poly_idx);
   assign wr_addr     = {wr_poly, FW'(op.face_idx)};

   // Walk position: the current polytope and whether this face ends it.
   assign cur_valid    = valid_ff[p_ff];
   assign cur_count    = count_ff[p_ff];
   assign face_is_last = ((CW'(f_ff) + CW'(1)) == cur_count);
   assign poly_is_last = (p_ff == PW'(NUM_POLYTOPES - 1));
   assign issue        = (state_ff == ST_WALK) && !hit_ff && cur_valid;

   // Sequencer for the walk over polytopes and faces.
   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      f_in     = f_ff;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_query) begin
               p_in     = '0;
               f_in     = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit_ff) begin
               state_in = ST_DRAIN;
            end else if (!cur_valid || face_is_last) begin
               f_in = '0;
               if (poly_is_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  p_in = p_ff + PW'(1);
               end
            end else begin
               f_in = f_ff + FW'(1);
            end
         end
         ST_DRAIN: begin
            if (!tag1_ff.v && !tag2_ff.v && !tag3_ff.v) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_full_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      p_ff <= p_in;
      f_ff <= f_in;
   end

   // Polytope table: valid bits and face counts.
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         for (int i = 0; i < NUM_POLYTOPES; i++) begin
            valid_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end
      end else if (do_write && op.face_last) begin
         valid_ff[wr_poly] <= 1'b1;
         count_ff[wr_poly] <= CW'(op.face_idx) + CW'(1);
      end
   end

   // Face memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_addr] <= {op.coef_x, op.coef_y, op.coef_z, op.face_bound};
      end
      if (issue) begin
         rd_data_ff <= mem[{p_ff, f_ff}];
      end
   end

   // Query point is held for the whole walk.
   always_ff @(posedge clock) begin
      if (start_query) begin
         pt_x_ff <= op.point_x;
         pt_y_ff <= op.point_y;
         pt_z_ff <= op.point_z;
      end
   end

   // Stage two: three products of coefficient and coordinate.
   assign {rd_coef_x, rd_coef_y, rd_coef_z, rd_bound} = rd_data_ff;

   always_ff @(posedge clock) begin
      prod_x_ff <= PROD_W'(rd_coef_x) * PROD_W'(pt_x_ff);
      prod_y_ff <= PROD_W'(rd_coef_y) * PROD_W'(pt_y_ff);
      prod_z_ff <= PROD_W'(rd_coef_z) * PROD_W'(pt_z_ff);
      bound2_ff <= rd_bound;
   end

   // Stage three: sum of the products.
   always_ff @(posedge clock) begin
      lhs_ff    <= SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff) + SUM_W'(prod_z_ff);
      bound3_ff <= bound2_ff;
   end

   // Pipeline tags follow the faces through the three stages.
   always_comb begin
      tag1_in.v     = issue;
      tag1_in.first = (f_ff == '0);
      tag1_in.last  = face_is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // Compare against the bound widened to the product scale; a polytope hits
   // when its last face arrives and none of its faces failed.
   assign rhs        = {bound3_ff, 16'b0};
   assign face_fails = (lhs_ff > SUM_W'(rhs));
   assign cur_fail   = (tag3_ff.first ? 1'b0 : fail_ff) | face_fails;

   always_comb begin
      hit_in  = hit_ff;
      fail_in = fail_ff;
      if (start_query) begin
         hit_in  = 1'b0;
         fail_in = 1'b0;
      end else if (tag3_ff.v) begin
         fail_in = cur_fail;
         if (tag3_ff.last && !cur_fail) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         fail_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         fail_ff <= fail_in;
      end
   end

   // Response register: one finished result waits here for the consumer.
   assign out_full_in = (out_full_ff && !rsp_pop) || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else begin
         out_full_ff <= out_full_in;
      end
      if (out_load) begin
         out_hit_ff <= hit_ff;
      end
   end

   assign rsp_empty = !out_full_ff;
   assign rsp_hit   = out_hit_ff;

endmodule

[rtl/point_in_polytope_collision_check.sv]
// Top level of the point-in-polytope collision check.
// Connects the front end, the operation queue and the back end; depends on pipc_pkg.
//
// Requests enter a two-entry queue and are carried out in order. A clear or a
// face write is carried out in the back end and returns nothing. A query walks
// the polytope table through the single read port of the face memory, one
// empty slot or one face of a valid polytope at a time, stopping after the
// first hit, and its result then passes through the compare pipeline to the
// response register. The face memory is not cleared at reset; only the faces
// of valid polytopes, below their face counts, are ever read.
module point_in_polytope_collision_check import pipc_pkg::*; #(
   parameter int NUM_POLYTOPES = 32,
   parameter int MAX_FACES     = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_cmd,
   input  logic [INDEX_W-1:0]         req_poly_index,
   input  logic [INDEX_W-1:0]         req_face_index,
   input  logic                       req_face_last,
   input  logic signed [COEF_W-1:0]   req_coef_x,
   input  logic signed [COEF_W-1:0]   req_coef_y,
   input  logic signed [COEF_W-1:0]   req_coef_z,
   input  logic signed [COORD_W-1:0]  req_face_bound,
   input  logic signed [COORD_W-1:0]  req_point_x,
   input  logic signed [COORD_W-1:0]  req_point_y,
   input  logic signed [COORD_W-1:0]  req_point_z,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_hit
);

   logic   queue_full;
   logic   op_push;
   op_type push_op;
   logic   op_valid;
   logic   op_pop;
   op_type head_op;

   pipc_front #(
      .NUM_POLYTOPES (NUM_POLYTOPES),
      .MAX_FACES     (MAX_FACES)
   ) u_front (
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_poly_index (req_poly_index),
      .req_face_index (req_face_index),
      .req_face_last  (req_face_last),
      .req_coef_x     (req_coef_x),
      .req_coef_y     (req_coef_y),
      .req_coef_z     (req_coef_z),
      .req_face_bound (req_face_bound),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .queue_full     (queue_full),
      .op_push        (op_push),
      .op             (push_op)
   );

   pipc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_push),
      .push_op (push_op),
      .full    (queue_full),
      .valid   (op_valid),
      .pop     (op_pop),
      .head_op (head_op)
   );

   pipc_back #(
      .NUM_POLYTOPES (NUM_POLYTOPES),
      .MAX_FACES     (MAX_FACES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (head_op),
      .op_pop    (op_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_hit   (rsp_hit)
   );

endmodule

[rtl/pipc_checker.sv]
// Port-level checker for the point-in-polytope collision check.
// Watches the request and response queue ports only; bound to the top level below.
module pipc_checker (
   input logic clock,
   input logic reset,
   input logic req_push,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic rsp_hit
);

   // After reset the request queue has room and no response waits, and no
   // response waits in the cycle after that either.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full) ##1 rsp_empty)
      else $error("response or full flag present right after reset");

   // A waiting response holds until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hit)))
      else $error("waiting response changed before it was popped");

   // The request queue only fills after an accepted request.
   a_full_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push && !req_full))
      else $error("request queue became full without an accepted request");

   // Both handshake flags are always known, and so is a waiting response.
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_full, rsp_empty}) && (rsp_empty || !$isunknown(rsp_hit)))
      else $error("handshake flag or waiting response is unknown");

endmodule

bind point_in_polytope_collision_check pipc_checker u_checker (.*);
